/* rtl/pcvb_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pcvb_pkg
// Shared types and constants for the point cloud voxel binner.
// ---------------------------------------------------------------------------
package pcvb_pkg;

    typedef enum logic [1:0] {
        OP_BOUND    = 2'd0,
        OP_NUCLEUS  = 2'd1,
        OP_ELECTRON = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    localparam logic CFG_VOXEL_SIZE = 1'b0;
    localparam logic CFG_GRID_DIM   = 1'b1;

    localparam logic [15:0] VOXEL_SIZE_RESET = 16'd128;
    localparam logic [5:0]  GRID_DIM_RESET   = 6'd32;

endpackage
`default_nettype wire

/* rtl/point_cloud_voxel_binner.sv */
`default_nettype none
// Placements are paced by the serial restoring divider shared by the three axes;
//   a new item is taken only once the previous one has been queued.
// Reset: synchronous active low; then a clearing pass over every counter
//   address zeroes the counter store, during which results wait.
// ---------------------------------------------------------------------------
// point_cloud_voxel_binner
// Bins 3-D points into a cubic grid of saturating voxel counters.
// ---------------------------------------------------------------------------
module point_cloud_voxel_binner
    import pcvb_pkg::*;
#(
    parameter int MAX_DIM    = 32,
    parameter int COUNT_BITS = 16,
    parameter int COORD_BITS = 20
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire                   cfg_index,
    input  wire  [15:0]           cfg_data,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [1:0]            s_opcode,
    input  wire  [COORD_BITS-1:0] s_coord_x,
    input  wire  [COORD_BITS-1:0] s_coord_y,
    input  wire  [COORD_BITS-1:0] s_coord_z,
    input  wire  [4:0]            s_read_x,
    input  wire  [4:0]            s_read_y,
    input  wire  [4:0]            s_read_z,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic                  m_status,
    output logic [4:0]            m_voxel_x,
    output logic [4:0]            m_voxel_y,
    output logic [4:0]            m_voxel_z,
    output logic [15:0]           m_protons,
    output logic [15:0]           m_neutrons,
    output logic [15:0]           m_electrons
);
    localparam int IW = $clog2(MAX_DIM);

    logic [15:0] voxel_size_reg;
    logic [5:0]  grid_dim_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voxel_size_reg <= VOXEL_SIZE_RESET;
            grid_dim_reg   <= GRID_DIM_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_VOXEL_SIZE) voxel_size_reg <= cfg_data;
            else grid_dim_reg <= cfg_data[5:0];
        end
    end

    logic          q_valid, q_ready, q_err;
    logic [1:0]    q_op;
    logic [IW-1:0] q_x, q_y, q_z;

    pcvb_front #(.MAX_DIM(MAX_DIM), .COORD_BITS(COORD_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode,
        .s_coord_x, .s_coord_y, .s_coord_z, .s_read_x, .s_read_y, .s_read_z,
        .voxel_size(voxel_size_reg), .grid_dim(grid_dim_reg),
        .q_valid, .q_ready, .q_op, .q_err, .q_x, .q_y, .q_z);

    pcvb_back #(.MAX_DIM(MAX_DIM), .COUNT_BITS(COUNT_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_op, .q_err, .q_x, .q_y, .q_z,
        .m_valid, .m_ready, .m_status, .m_voxel_x, .m_voxel_y, .m_voxel_z,
        .m_protons, .m_neutrons, .m_electrons);
endmodule
`default_nettype wire

/* rtl/pcvb_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pcvb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module pcvb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/pcvb_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pcvb_front
// Accepts items, tracks minima, computes voxel indices with a shared serial
// divider and pushes classified commands into a one-entry queue.
// ---------------------------------------------------------------------------
module pcvb_front
    import pcvb_pkg::*;
#(
    parameter int MAX_DIM    = 32,
    parameter int COORD_BITS = 20,
    localparam int IW = $clog2(MAX_DIM)
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [1:0]            s_opcode,
    input  wire  [COORD_BITS-1:0] s_coord_x,
    input  wire  [COORD_BITS-1:0] s_coord_y,
    input  wire  [COORD_BITS-1:0] s_coord_z,
    input  wire  [4:0]            s_read_x,
    input  wire  [4:0]            s_read_y,
    input  wire  [4:0]            s_read_z,
    input  wire  [15:0]           voxel_size,
    input  wire  [5:0]            grid_dim,
    output logic                  q_valid,
    input  wire                   q_ready,
    output logic [1:0]            q_op,
    output logic                  q_err,
    output logic [IW-1:0]         q_x,
    output logic [IW-1:0]         q_y,
    output logic [IW-1:0]         q_z
);
    localparam int SW = COORD_BITS + 1;   // magnitude of a difference
    localparam int CW = $clog2(SW + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_NEXT = 4'b0100,
        ST_PUSH = 4'b1000
    } st_t;

    st_t st_reg, st_next;
    logic signed [COORD_BITS-1:0] min_reg [3];
    logic signed [COORD_BITS-1:0] crd_reg [3];
    logic [1:0]    op_reg;
    logic [1:0]    axis_reg;
    logic [SW-1:0] num_reg;    // shifts out as quotient
    logic [16:0]   rem_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          err_reg;
    logic [IW-1:0] idx_reg [3];
    logic          qv_reg;

    logic [6:0] eff_dim;
    assign eff_dim = ({1'b0, grid_dim} > 7'(MAX_DIM)) ? 7'(MAX_DIM) : {1'b0, grid_dim};

    logic signed [SW-1:0] diff;
    logic [SW-1:0] mag;
    assign diff = SW'(crd_reg[axis_reg]) - SW'(min_reg[axis_reg]);
    assign mag  = diff[SW-1] ? SW'(-diff) : SW'(diff);

    logic [17:0] trial;
    assign trial = {rem_reg, num_reg[SW-1]} - {2'b0, voxel_size};

    // quotient including the bit produced by the current step
    logic [SW-1:0] quo;
    assign quo = {num_reg[SW-2:0], ~trial[17]};

    logic quo_bad;
    assign quo_bad = (neg_reg && quo != '0) || (quo >= SW'(eff_dim));

    logic push;
    assign push = (st_reg == ST_PUSH) && (!qv_reg || q_ready);

    assign s_ready = (st_reg == ST_IDLE);
    assign q_valid = qv_reg;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (s_valid) begin
                if (s_opcode inside {OP_BOUND, OP_READ}) st_next = ST_PUSH;
                else st_next = ST_NEXT;
            end
            ST_NEXT: st_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) st_next = (axis_reg == 2'd2) ? ST_PUSH : ST_NEXT;
            ST_PUSH: if (!qv_reg || q_ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            qv_reg <= 1'b0;
            for (int i = 0; i < 3; i++) min_reg[i] <= '0;
        end else begin
            st_reg <= st_next;
            if (push) qv_reg <= 1'b1;
            else if (q_ready) qv_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: if (s_valid) begin
                    op_reg     <= s_opcode;
                    crd_reg[0] <= s_coord_x;
                    crd_reg[1] <= s_coord_y;
                    crd_reg[2] <= s_coord_z;
                    axis_reg   <= 2'd0;
                    case (s_opcode)
                        OP_BOUND: begin
                            err_reg <= 1'b0;
                            if ($signed(s_coord_x) < min_reg[0]) min_reg[0] <= s_coord_x;
                            if ($signed(s_coord_y) < min_reg[1]) min_reg[1] <= s_coord_y;
                            if ($signed(s_coord_z) < min_reg[2]) min_reg[2] <= s_coord_z;
                        end
                        OP_READ: begin
                            err_reg <= (7'(s_read_x) >= eff_dim) || (7'(s_read_y) >= eff_dim)
                                    || (7'(s_read_z) >= eff_dim);
                            idx_reg[0] <= IW'(s_read_x);
                            idx_reg[1] <= IW'(s_read_y);
                            idx_reg[2] <= IW'(s_read_z);
                        end
                        default: err_reg <= (voxel_size == '0);
                    endcase
                end
                ST_NEXT: begin
                    num_reg <= mag;
                    neg_reg <= diff[SW-1];
                    rem_reg <= '0;
                    cnt_reg <= CW'(SW - 1);
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (!trial[17]) rem_reg <= trial[16:0];
                    else rem_reg <= {rem_reg[15:0], num_reg[SW-1]};
                    num_reg <= quo;
                    if (cnt_reg != '0) begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end else begin
                        idx_reg[axis_reg] <= IW'(quo);
                        if (quo_bad) err_reg <= 1'b1;
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_op  <= op_reg;
            q_err <= err_reg;
            q_x   <= idx_reg[0];
            q_y   <= idx_reg[1];
            q_z   <= idx_reg[2];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_ready |=> q_valid)
        else $error("queue entry dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front accepted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(st_reg))
        else $error("front state corrupt");
endmodule
`default_nettype wire

/* rtl/pcvb_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pcvb_back
// Clears the counter store after reset, then performs read-modify-write
// and read commands and registers one result.
// ---------------------------------------------------------------------------
module pcvb_back
    import pcvb_pkg::*;
#(
    parameter int MAX_DIM    = 32,
    parameter int COUNT_BITS = 16,
    localparam int IW = $clog2(MAX_DIM),
    localparam int AW = 3 * IW
) (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           q_valid,
    output logic          q_ready,
    input  wire  [1:0]    q_op,
    input  wire           q_err,
    input  wire  [IW-1:0] q_x,
    input  wire  [IW-1:0] q_y,
    input  wire  [IW-1:0] q_z,
    output logic          m_valid,
    input  wire           m_ready,
    output logic          m_status,
    output logic [4:0]    m_voxel_x,
    output logic [4:0]    m_voxel_y,
    output logic [4:0]    m_voxel_z,
    output logic [15:0]   m_protons,
    output logic [15:0]   m_neutrons,
    output logic [15:0]   m_electrons
);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [4:0] {
        B_CLEAR = 5'b00001,
        B_IDLE  = 5'b00010,
        B_READ  = 5'b00100,
        B_WRITE = 5'b01000,
        B_OUT   = 5'b10000
    } bst_t;

    bst_t st_reg;
    logic [AW-1:0]   clr_reg;
    logic [AW-1:0]   addr_reg;
    logic [1:0]      op_reg;
    logic            err_reg;
    logic [IW-1:0]   x_reg, y_reg, z_reg;
    logic            mv_reg;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [COUNT_BITS-1:0] nuc_w, ele_w, nuc_r, ele_r;
    logic                  nuc_we, ele_we;

    pcvb_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << AW)) u_nuc (
        .aclk(aclk), .we(nuc_we), .waddr(waddr), .wdata(nuc_w),
        .raddr(addr_reg), .rdata(nuc_r));
    pcvb_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << AW)) u_ele (
        .aclk(aclk), .we(ele_we), .waddr(waddr), .wdata(ele_w),
        .raddr(addr_reg), .rdata(ele_r));

    logic clearing;
    assign clearing = (st_reg == B_CLEAR);
    assign we     = (st_reg == B_WRITE) && !err_reg;
    assign waddr  = clearing ? clr_reg : addr_reg;
    assign nuc_we = clearing || (we && op_reg == OP_NUCLEUS && nuc_r != CMAX);
    assign ele_we = clearing || (we && op_reg == OP_ELECTRON && ele_r != CMAX);
    assign nuc_w  = clearing ? '0 : nuc_r + 1'b1;
    assign ele_w  = clearing ? '0 : ele_r + 1'b1;

    logic out_fire;
    assign out_fire = (st_reg == B_OUT) && (!mv_reg || m_ready);

    assign q_ready = (st_reg == B_IDLE);
    assign m_valid = mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= B_CLEAR;
            clr_reg <= '0;
            mv_reg  <= 1'b0;
        end else begin
            if (out_fire) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
            case (st_reg)
                B_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1) st_reg <= B_IDLE;
                end
                B_IDLE: if (q_valid) begin
                    op_reg   <= q_op;
                    err_reg  <= q_err;
                    x_reg    <= q_x;
                    y_reg    <= q_y;
                    z_reg    <= q_z;
                    addr_reg <= {q_x, q_y, q_z};
                    st_reg   <= B_READ;
                end
                B_READ:  st_reg <= B_WRITE;
                B_WRITE: st_reg <= B_OUT;
                B_OUT: if (!mv_reg || m_ready) begin
                    st_reg <= B_IDLE;
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    // hold write data of the RMW for the result
    logic [COUNT_BITS-1:0] nuc_h, ele_h;
    always_ff @(posedge aclk) begin
        if (st_reg == B_WRITE) begin
            nuc_h <= nuc_we ? nuc_w : nuc_r;
            ele_h <= ele_we ? ele_w : ele_r;
        end
        if (out_fire) begin
            m_status    <= err_reg;
            if (err_reg || op_reg == OP_BOUND) begin
                m_voxel_x   <= '0;
                m_voxel_y   <= '0;
                m_voxel_z   <= '0;
                m_protons   <= '0;
                m_neutrons  <= '0;
                m_electrons <= '0;
            end else begin
                m_voxel_x   <= 5'(x_reg);
                m_voxel_y   <= 5'(y_reg);
                m_voxel_z   <= 5'(z_reg);
                m_protons   <= 16'(nuc_h);
                m_neutrons  <= 16'(nuc_h);
                m_electrons <= 16'(ele_h);
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !q_ready)
        else $error("command taken during clear");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_protons == '0 && m_electrons == '0)
        else $error("error result carries counts");
endmodule
`default_nettype wire

/* tb/sv/point_cloud_voxel_binner_tb.sv */
// ---------------------------------------------------------------------------
// point_cloud_voxel_binner_tb
// Self-checking bench: random valid/ready traffic on the point and result
// channels, register writes between phases, and a scoreboard fed by an
// in-bench model of the voxel counters and axis minima.
// ---------------------------------------------------------------------------
module point_cloud_voxel_binner_tb;
    import pcvb_pkg::*;

    localparam int GRID  = 32;
    localparam int CELLS = GRID * GRID * GRID;
    localparam int WDOG_LIMIT = 80000;

    typedef struct {
        op_t        op;
        logic [19:0] cx, cy, cz;
        logic [4:0]  rx, ry, rz;
    } point_t;

    typedef struct {
        logic        status;
        logic [4:0]  vx, vy, vz;
        logic [15:0] protons, neutrons, electrons;
    } voxel_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [19:0] s_coord_x = '0, s_coord_y = '0, s_coord_z = '0;
    logic [4:0]  s_read_x = '0, s_read_y = '0, s_read_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic [4:0]  m_voxel_x, m_voxel_y, m_voxel_z;
    logic [15:0] m_protons, m_neutrons, m_electrons;

    point_cloud_voxel_binner dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y), .s_coord_z(s_coord_z),
        .s_read_x(s_read_x), .s_read_y(s_read_y), .s_read_z(s_read_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_voxel_x(m_voxel_x), .m_voxel_y(m_voxel_y), .m_voxel_z(m_voxel_z),
        .m_protons(m_protons), .m_neutrons(m_neutrons), .m_electrons(m_electrons)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // model state, updated on accepted transactions
    logic [15:0] nuc_cnt [CELLS];
    logic [15:0] ele_cnt [CELLS];
    int          min_x, min_y, min_z;
    logic [15:0] vox_size;
    logic [5:0]  grid_dim;

    // generator view of the same state, at queueing time
    int          gen_min_x, gen_min_y, gen_min_z;
    int          gen_size, gen_dim;

    point_t      pending_points[$];
    point_t      cur_point;
    voxel_rec_t  expected_voxels[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    bit          src_hold = 1'b0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    function automatic int eff_dim();
        return (grid_dim > GRID) ? GRID : int'(grid_dim);
    endfunction

    function automatic bit axis_bin(input logic [19:0] c, input int mn, output int idx);
        int sum;
        sum = int'($signed(c)) - mn;
        idx = sum / int'(vox_size);
        return (idx >= 0 && idx < eff_dim());
    endfunction

    function automatic voxel_rec_t bin_point(input point_t p);
        voxel_rec_t r;
        int x, y, z, slot;
        bit ok;
        r = '{default: '0};
        if (p.op == OP_BOUND) begin
            if (int'($signed(p.cx)) < min_x) min_x = int'($signed(p.cx));
            if (int'($signed(p.cy)) < min_y) min_y = int'($signed(p.cy));
            if (int'($signed(p.cz)) < min_z) min_z = int'($signed(p.cz));
            return r;
        end
        if (p.op == OP_READ) begin
            x = int'(p.rx); y = int'(p.ry); z = int'(p.rz);
            if (x >= eff_dim() || y >= eff_dim() || z >= eff_dim()) begin
                r.status = 1'b1;
                return r;
            end
            slot = (x * GRID + y) * GRID + z;
        end else begin
            ok = (vox_size != 0);
            if (ok) ok = axis_bin(p.cx, min_x, x);
            if (ok) ok = axis_bin(p.cy, min_y, y);
            if (ok) ok = axis_bin(p.cz, min_z, z);
            if (!ok) begin
                r.status = 1'b1;
                return r;
            end
            slot = (x * GRID + y) * GRID + z;
            if (p.op == OP_NUCLEUS) begin
                if (nuc_cnt[slot] != 16'hFFFF) nuc_cnt[slot] = nuc_cnt[slot] + 16'd1;
            end else begin
                if (ele_cnt[slot] != 16'hFFFF) ele_cnt[slot] = ele_cnt[slot] + 16'd1;
            end
        end
        r.vx = 5'(x); r.vy = 5'(y); r.vz = 5'(z);
        r.protons   = nuc_cnt[slot];
        r.neutrons  = nuc_cnt[slot];
        r.electrons = ele_cnt[slot];
        return r;
    endfunction

    function automatic logic [19:0] aim_axis(input int gmin);
        int dim, idx, off;
        dim = (gen_dim > GRID) ? GRID : gen_dim;
        idx = (dim == 0) ? 0 : $urandom_range(dim - 1, 0);
        if ($urandom_range(99, 0) < 8) idx = dim;
        if (gen_size > 0) off = idx * gen_size + $urandom_range(gen_size - 1, 0);
        else off = $urandom_range(4095, 0);
        if ($urandom_range(99, 0) < 5) off = -$urandom_range(300, 1);
        return 20'(gmin + off);
    endfunction

    task automatic queue_point(input op_t op, input int x, input int y, input int z,
                               input int rx = 0, input int ry = 0, input int rz = 0);
        point_t p;
        p.op = op;
        p.cx = 20'(x); p.cy = 20'(y); p.cz = 20'(z);
        p.rx = 5'(rx); p.ry = 5'(ry); p.rz = 5'(rz);
        if (op == OP_BOUND) begin
            if (int'($signed(p.cx)) < gen_min_x) gen_min_x = int'($signed(p.cx));
            if (int'($signed(p.cy)) < gen_min_y) gen_min_y = int'($signed(p.cy));
            if (int'($signed(p.cz)) < gen_min_z) gen_min_z = int'($signed(p.cz));
        end
        pending_points.push_back(p);
    endtask

    task automatic queue_random(input int count);
        int k, sel;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(99, 0);
            if (sel < 8) begin
                queue_point(OP_BOUND, gen_min_x - $urandom_range(200, 0),
                            gen_min_y - $urandom_range(200, 0),
                            gen_min_z - $urandom_range(200, 0));
            end else if (sel < 20) begin
                queue_point(OP_READ, 0, 0, 0, $urandom_range(31, 0),
                            $urandom_range(31, 0), $urandom_range(31, 0));
            end else if (sel < 28) begin
                queue_point(op_t'($urandom_range(3, 0)), $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom);
            end else begin
                queue_point(($urandom_range(1, 0) != 0) ? OP_NUCLEUS : OP_ELECTRON,
                            aim_axis(gen_min_x), aim_axis(gen_min_y), aim_axis(gen_min_z));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || s_valid || expected_voxels.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_VOXEL_SIZE) gen_size = value;
        else gen_dim = value[5:0];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // driver: present the next point, update the model on acceptance
    always @(posedge aclk) begin
        logic launch;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_voxels.push_back(bin_point(cur_point));
            end
            if (!s_valid || s_ready) begin
                launch = pending_points.size() != 0 && !src_hold &&
                         (quiet || $urandom_range(99, 0) >= 11);
                if (launch) begin
                    cur_point = pending_points.pop_front();
                    s_opcode  <= cur_point.op;
                    s_coord_x <= cur_point.cx;
                    s_coord_y <= cur_point.cy;
                    s_coord_z <= cur_point.cz;
                    s_read_x  <= cur_point.rx;
                    s_read_y  <= cur_point.ry;
                    s_read_z  <= cur_point.rz;
                end
                s_valid <= launch;
            end
        end
    end

    // result side ready, with a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = 600;
        end
        if (hold_left > 0) hold_left--;
        m_ready <= (hold_left == 0) && (quiet || $urandom_range(99, 0) >= 11);
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        voxel_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_voxels.size() == 0) begin
                report_mismatch("unexpected result transaction", 1, 0);
            end else begin
                want = expected_voxels.pop_front();
                if (m_status !== want.status) report_mismatch("status", m_status, want.status);
                if (m_voxel_x !== want.vx) report_mismatch("voxel_x", m_voxel_x, want.vx);
                if (m_voxel_y !== want.vy) report_mismatch("voxel_y", m_voxel_y, want.vy);
                if (m_voxel_z !== want.vz) report_mismatch("voxel_z", m_voxel_z, want.vz);
                if (m_protons !== want.protons)
                    report_mismatch("protons", m_protons, want.protons);
                if (m_neutrons !== want.neutrons)
                    report_mismatch("neutrons", m_neutrons, want.neutrons);
                if (m_electrons !== want.electrons)
                    report_mismatch("electrons", m_electrons, want.electrons);
            end
        end
    end

    // mirror register writes into the model
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_VOXEL_SIZE) vox_size = cfg_data;
            else grid_dim = cfg_data[5:0];
        end
    end

    // watchdog: covers the clearing pass after reset
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            nuc_cnt[i] = '0;
            ele_cnt[i] = '0;
        end
        min_x = 0; min_y = 0; min_z = 0;
        vox_size = VOXEL_SIZE_RESET;
        grid_dim = GRID_DIM_RESET;
        gen_min_x = 0; gen_min_y = 0; gen_min_z = 0;
        gen_size = VOXEL_SIZE_RESET;
        gen_dim = GRID_DIM_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: grid corners, edge of grid, small negative sums, extremes
        queue_point(OP_READ, 0, 0, 0, 0, 0, 0);
        queue_point(OP_READ, 0, 0, 0, 31, 31, 31);
        queue_point(OP_NUCLEUS, 0, 0, 0);
        queue_point(OP_ELECTRON, 4095, 4095, 4095);
        queue_point(OP_NUCLEUS, 4096, 0, 0);
        queue_point(OP_NUCLEUS, -1, -127, 0);
        queue_point(OP_ELECTRON, 0, -128, 0);
        queue_point(OP_BOUND, -256, -300, -1);
        queue_point(OP_NUCLEUS, -256, -300, -1);
        queue_point(OP_READ, 0, 0, 0, 0, 0, 0);
        queue_point(OP_BOUND, 524287, 524287, 524287);
        queue_point(OP_NUCLEUS, 524287, 524287, 524287);
        queue_point(OP_ELECTRON, -524288, 0, 0);
        queue_point(OP_READ, 0, 0, 0, 31, 0, 31);
        queue_point(OP_NUCLEUS, 0, 0, 0, 31, 31, 31);
        queue_random(240);
        wait_drained();

        // fill the block while the receiver holds off
        write_reg(CFG_VOXEL_SIZE, 16'd256);
        write_reg(CFG_GRID_DIM, 16'd16);
        hold_req++;
        queue_random(260);
        wait_drained();

        write_reg(CFG_VOXEL_SIZE, 16'd1);
        write_reg(CFG_GRID_DIM, 16'd63);
        quiet = 1'b1;
        queue_random(260);
        wait_drained();
        quiet = 1'b0;

        write_reg(CFG_VOXEL_SIZE, 16'hFFFF);
        write_reg(CFG_GRID_DIM, 16'd1);
        queue_random(200);
        // pause the sender until every result is back
        src_hold = 1'b1;
        while (expected_voxels.size() != 0 || s_valid) @(posedge aclk);
        src_hold = 1'b0;
        queue_random(60);
        wait_drained();

        write_reg(CFG_VOXEL_SIZE, 16'd0);
        write_reg(CFG_GRID_DIM, 16'd32);
        queue_random(200);
        wait_drained();

        write_reg(CFG_VOXEL_SIZE, 16'd100);
        write_reg(CFG_GRID_DIM, 16'd0);
        queue_random(200);
        wait_drained();

        write_reg(CFG_VOXEL_SIZE, 16'd200);
        write_reg(CFG_GRID_DIM, 16'd32);
        queue_random(520);
        wait_drained();

        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_voxels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/pcvb_pkg.sv
rtl/pcvb_ram.sv
rtl/pcvb_front.sv
rtl/pcvb_back.sv
rtl/point_cloud_voxel_binner.sv
tb/sv/point_cloud_voxel_binner_tb.sv
